@@ rtl/btc_pkg.sv @@
// Shared types and constants of the ball tracking head controller.
package btc_pkg;

    localparam int ANG_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int GAIN_W     = 13;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_LEFT_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_RIGHT_LIMIT = 2'd3;

    localparam int IMAGE_WIDTH_RESET  = 640;
    localparam int IMAGE_HEIGHT_RESET = 480;
    localparam logic signed [ANG_W-1:0] PAN_LEFT_RESET  = -17'sd23040;
    localparam logic signed [ANG_W-1:0] PAN_RIGHT_RESET = 17'sd23040;

    // Gains pre-scaled to 1/256 degree: 15 * 256 and 20 * 256
    localparam logic [GAIN_W-1:0] TILT_GAIN_Q8 = 13'd3840;
    localparam logic [GAIN_W-1:0] PAN_GAIN_Q8  = 13'd5120;

    localparam int ONE_DEG_Q8  = 256;
    localparam int TILT_MAX_Q8 = 22784;

    localparam logic signed [ANG_W-1:0] SWEEP_HIGH_TILT = 17'sd15360;
    localparam logic signed [ANG_W-1:0] SWEEP_LOW_TILT  = 17'sd11520;

    typedef enum logic [1:0] {
        VERDICT_FINDING = 2'd0,
        VERDICT_FOUND   = 2'd1,
        VERDICT_LEFT    = 2'd2,
        VERDICT_RIGHT   = 2'd3
    } btc_verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_TILT,
        ST_DIV_PAN,
        ST_EMIT
    } btc_state_t;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic start_tilt;
        logic start_pan;
        logic commit;
    } btc_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic slot_free;
    } btc_stat_t;

endpackage

@@ rtl/btc_if.sv @@
// Channel interfaces: frame reports in, head commands out, register writes.
interface btc_report_if #(
    parameter int COORD_BITS = 12
);
    logic                               valid;
    logic                               ready;
    logic                               ball_seen;
    logic [COORD_BITS-1:0]              ball_col;
    logic [COORD_BITS-1:0]              ball_row;
    logic signed [btc_pkg::ANG_W-1:0]   tilt_now;
    logic signed [btc_pkg::ANG_W-1:0]   pan_now;
    logic                               head_moving;

    modport source (
        output valid, ball_seen, ball_col, ball_row, tilt_now, pan_now, head_moving,
        input  ready
    );
    modport sink (
        input  valid, ball_seen, ball_col, ball_row, tilt_now, pan_now, head_moving,
        output ready
    );
endinterface

interface btc_command_if;
    logic                               valid;
    logic                               ready;
    btc_pkg::btc_verdict_t              verdict;
    logic                               move_valid;
    logic signed [btc_pkg::ANG_W-1:0]   tilt_target;
    logic signed [btc_pkg::ANG_W-1:0]   pan_target;

    modport source (
        output valid, verdict, move_valid, tilt_target, pan_target,
        input  ready
    );
    modport sink (
        input  valid, verdict, move_valid, tilt_target, pan_target,
        output ready
    );
endinterface

interface btc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [btc_pkg::CFG_IDX_W-1:0]       index;
    logic [btc_pkg::CFG_DATA_W-1:0]      data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ rtl/btc_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module btc_div #(
    parameter int W = 25
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quotient,
    output logic         done
);

    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dsr_reg;

    logic [W:0]       rem_shift;
    logic             fits;
    logic [W:0]       rem_sub;
    logic [W-1:0]     rem_next;
    logic [W-1:0]     quo_next;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[W-1]};
        fits      = rem_shift >= {1'b0, dsr_reg};
        rem_sub   = rem_shift - {1'b0, dsr_reg};
        rem_next  = fits ? rem_sub[W-1:0] : rem_shift[W-1:0];
        quo_next  = {quo_reg[W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ rtl/btc_ctrl.sv @@
// Sequencer: accepts a report, runs the two divisions when needed, emits the word.
module btc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                report_valid,
    input  btc_pkg::btc_stat_t  stat,
    output btc_pkg::btc_cmd_t   cmd
);

    btc_pkg::btc_state_t state_reg;
    btc_pkg::btc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            btc_pkg::ST_IDLE:
            begin
                if (report_valid)
                begin
                    state_next = btc_pkg::ST_PREP;
                end
            end
            btc_pkg::ST_PREP:
            begin
                state_next = stat.need_div ? btc_pkg::ST_DIV_TILT : btc_pkg::ST_EMIT;
            end
            btc_pkg::ST_DIV_TILT:
            begin
                if (stat.div_done)
                begin
                    state_next = btc_pkg::ST_DIV_PAN;
                end
            end
            btc_pkg::ST_DIV_PAN:
            begin
                if (stat.div_done)
                begin
                    state_next = btc_pkg::ST_EMIT;
                end
            end
            btc_pkg::ST_EMIT:
            begin
                if (stat.slot_free)
                begin
                    state_next = btc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = btc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            btc_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.load     = report_valid;
            end
            btc_pkg::ST_PREP:
            begin
                cmd.start_tilt = stat.need_div;
            end
            btc_pkg::ST_DIV_TILT:
            begin
                cmd.start_pan = stat.div_done;
            end
            btc_pkg::ST_DIV_PAN:
            begin
                cmd = '0;
            end
            btc_pkg::ST_EMIT:
            begin
                cmd.commit = stat.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/btc_dp.sv @@
// Datapath: registers, centre test, angle corrections, sweep logic, output register.
module btc_dp #(
    parameter int COORD_BITS         = 12,
    parameter int PASSES_BEFORE_TURN = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  btc_pkg::btc_cmd_t                 cmd,
    output btc_pkg::btc_stat_t                stat,
    input  logic                              cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [btc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              ball_seen,
    input  logic [COORD_BITS-1:0]             ball_col,
    input  logic [COORD_BITS-1:0]             ball_row,
    input  logic signed [btc_pkg::ANG_W-1:0]  tilt_now,
    input  logic signed [btc_pkg::ANG_W-1:0]  pan_now,
    input  logic                              head_moving,
    btc_command_if.source                     command
);

    localparam int CB    = COORD_BITS;
    localparam int AW    = btc_pkg::ANG_W;
    localparam int MAG_W = COORD_BITS + btc_pkg::GAIN_W;
    localparam int SUM_W = MAG_W + 2;

    localparam logic signed [SUM_W-1:0] ONE_DEG  = SUM_W'(btc_pkg::ONE_DEG_Q8);
    localparam logic signed [SUM_W-1:0] TILT_MAX = SUM_W'(btc_pkg::TILT_MAX_Q8);
    localparam logic [1:0]              PASS_LIM = 2'(PASSES_BEFORE_TURN);

    // Configuration
    logic [CB-1:0]          width_reg;
    logic [CB-1:0]          height_reg;
    logic signed [AW-1:0]   left_reg;
    logic signed [AW-1:0]   right_reg;

    // Latched report
    logic                   seen_reg;
    logic [CB-1:0]          col_reg;
    logic [CB-1:0]          row_reg;
    logic signed [AW-1:0]   tilt_reg;
    logic signed [AW-1:0]   pan_reg;
    logic                   moving_reg;

    // Tracking state
    logic                   sweep_dir_reg;
    logic                   saw_reg;
    logic [CB-1:0]          last_col_reg;
    logic [1:0]             passes_reg;

    // Division results
    logic                   div_for_pan_reg;
    logic [MAG_W-1:0]       qt_reg;
    logic [MAG_W-1:0]       qp_reg;

    // Output register
    logic                   out_valid_reg;
    btc_pkg::btc_verdict_t  verdict_reg;
    logic                   move_reg;
    logic signed [AW-1:0]   tilt_out_reg;
    logic signed [AW-1:0]   pan_out_reg;

    // Combinational
    logic [CB-1:0]          hw;
    logic [CB-1:0]          hh;
    logic [CB-1:0]          w_q1;
    logic [CB-1:0]          h_q1;
    logic [CB+1:0]          w_q3;
    logic [CB+1:0]          h_q3;
    logic                   in_centre;
    logic signed [CB:0]     tdiff;
    logic signed [CB:0]     pdiff;
    logic                   tneg;
    logic                   pneg;
    logic [CB:0]            tabs_full;
    logic [CB:0]            pabs_full;
    logic [MAG_W-1:0]       tilt_dvd;
    logic [MAG_W-1:0]       pan_dvd;
    logic [MAG_W-1:0]       div_dvd;
    logic [MAG_W-1:0]       div_dsr;
    logic [MAG_W-1:0]       div_q;
    logic                   div_done;
    logic signed [SUM_W-1:0] qt_ext;
    logic signed [SUM_W-1:0] qp_ext;
    logic signed [SUM_W-1:0] tcorr;
    logic signed [SUM_W-1:0] pcorr;
    logic signed [SUM_W-1:0] tt;
    logic signed [SUM_W-1:0] pt;
    logic signed [SUM_W-1:0] left_ext;
    logic signed [SUM_W-1:0] right_ext;
    logic signed [SUM_W-1:0] pt_clamp;
    logic [1:0]             passes_inc;

    btc_pkg::btc_verdict_t  res_verdict;
    logic                   res_move;
    logic signed [AW-1:0]   res_tilt;
    logic signed [AW-1:0]   res_pan;
    logic                   sweep_dir_next;
    logic                   saw_next;
    logic [CB-1:0]          last_col_next;
    logic [1:0]             passes_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CB'(btc_pkg::IMAGE_WIDTH_RESET);
            height_reg <= CB'(btc_pkg::IMAGE_HEIGHT_RESET);
            left_reg   <= btc_pkg::PAN_LEFT_RESET;
            right_reg  <= btc_pkg::PAN_RIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                btc_pkg::REG_IMAGE_WIDTH:     width_reg  <= cfg_data[CB-1:0];
                btc_pkg::REG_IMAGE_HEIGHT:    height_reg <= cfg_data[CB-1:0];
                btc_pkg::REG_PAN_LEFT_LIMIT:  left_reg   <= $signed(cfg_data);
                btc_pkg::REG_PAN_RIGHT_LIMIT: right_reg  <= $signed(cfg_data);
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            seen_reg   <= ball_seen;
            col_reg    <= ball_col;
            row_reg    <= ball_row;
            tilt_reg   <= tilt_now;
            pan_reg    <= pan_now;
            moving_reg <= head_moving;
        end
        if (div_done)
        begin
            if (div_for_pan_reg)
            begin
                qp_reg <= div_q;
            end
            else
            begin
                qt_reg <= div_q;
            end
        end
    end

    // Centre quarter-rectangle, bounds inclusive
    always_comb
    begin
        hw        = {1'b0, width_reg[CB-1:1]};
        hh        = {1'b0, height_reg[CB-1:1]};
        w_q1      = {2'b00, width_reg[CB-1:2]};
        h_q1      = {2'b00, height_reg[CB-1:2]};
        w_q3      = ({2'b00, width_reg} + {1'b0, width_reg, 1'b0}) >> 2;
        h_q3      = ({2'b00, height_reg} + {1'b0, height_reg, 1'b0}) >> 2;
        in_centre = (col_reg >= w_q1) && ({2'b00, col_reg} <= w_q3) &&
                    (row_reg >= h_q1) && ({2'b00, row_reg} <= h_q3);
    end

    // Divide magnitudes, restore the sign afterwards: truncation toward zero
    always_comb
    begin
        tdiff     = $signed({1'b0, hh}) - $signed({1'b0, row_reg});
        pdiff     = $signed({1'b0, col_reg}) - $signed({1'b0, hw});
        tneg      = tdiff[CB];
        pneg      = pdiff[CB];
        tabs_full = tneg ? (~tdiff + 1'b1) : tdiff;
        pabs_full = pneg ? (~pdiff + 1'b1) : pdiff;
        tilt_dvd  = MAG_W'(tabs_full[CB-1:0]) * MAG_W'(btc_pkg::TILT_GAIN_Q8);
        pan_dvd   = MAG_W'(pabs_full[CB-1:0]) * MAG_W'(btc_pkg::PAN_GAIN_Q8);
        div_dvd   = cmd.start_pan ? pan_dvd : tilt_dvd;
        div_dsr   = cmd.start_pan ? MAG_W'(hw) : MAG_W'(hh);
    end

    btc_div #(
        .W (MAG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_tilt | cmd.start_pan),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .quotient (div_q),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_for_pan_reg <= 1'b0;
        end
        else if (cmd.start_tilt)
        begin
            div_for_pan_reg <= 1'b0;
        end
        else if (cmd.start_pan)
        begin
            div_for_pan_reg <= 1'b1;
        end
    end

    always_comb
    begin
        qt_ext    = $signed({2'b00, qt_reg});
        qp_ext    = $signed({2'b00, qp_reg});
        tcorr     = (hh == '0) ? '0 : (tneg ? -qt_ext : qt_ext);
        pcorr     = (hw == '0) ? '0 : (pneg ? -qp_ext : qp_ext);
        tt        = $signed({{(SUM_W-AW){tilt_reg[AW-1]}}, tilt_reg}) + tcorr;
        pt        = $signed({{(SUM_W-AW){pan_reg[AW-1]}}, pan_reg}) + pcorr;
        left_ext  = $signed({{(SUM_W-AW){left_reg[AW-1]}}, left_reg});
        right_ext = $signed({{(SUM_W-AW){right_reg[AW-1]}}, right_reg});
        if (pt < left_ext)
        begin
            pt_clamp = left_ext;
        end
        else if (pt > right_ext)
        begin
            pt_clamp = right_ext;
        end
        else
        begin
            pt_clamp = pt;
        end
        passes_inc = passes_reg + 2'd1;
    end

    // Result and next tracking state for the held report
    always_comb
    begin
        res_verdict    = btc_pkg::VERDICT_FINDING;
        res_move       = 1'b0;
        res_tilt       = '0;
        res_pan        = '0;
        sweep_dir_next = sweep_dir_reg;
        saw_next       = saw_reg;
        last_col_next  = last_col_reg;
        passes_next    = passes_reg;
        if (seen_reg)
        begin
            last_col_next = col_reg;
            saw_next      = 1'b1;
            if (in_centre)
            begin
                res_verdict = btc_pkg::VERDICT_FOUND;
                saw_next    = 1'b0;
                passes_next = 2'd0;
            end
            else if (!((tt <= ONE_DEG) || (tt >= TILT_MAX)))
            begin
                res_move = 1'b1;
                res_tilt = tt[AW-1:0];
                res_pan  = pt_clamp[AW-1:0];
                if (pt >= right_ext - ONE_DEG)
                begin
                    res_verdict = btc_pkg::VERDICT_RIGHT;
                end
                else if (pt <= left_ext + ONE_DEG)
                begin
                    res_verdict = btc_pkg::VERDICT_LEFT;
                end
            end
        end
        else if (saw_reg)
        begin
            // Sweep first away from the side where the ball was last seen
            saw_next = 1'b0;
            res_move = 1'b1;
            if ({1'b0, last_col_reg} > {1'b0, hw})
            begin
                sweep_dir_next = 1'b1;
                res_tilt       = btc_pkg::SWEEP_HIGH_TILT;
                res_pan        = left_reg;
            end
            else
            begin
                sweep_dir_next = 1'b0;
                res_tilt       = btc_pkg::SWEEP_LOW_TILT;
                res_pan        = right_reg;
            end
        end
        else if (!moving_reg)
        begin
            res_move       = 1'b1;
            sweep_dir_next = !sweep_dir_reg;
            if (!sweep_dir_reg)
            begin
                res_tilt = btc_pkg::SWEEP_HIGH_TILT;
                res_pan  = left_reg;
            end
            else
            begin
                res_tilt = btc_pkg::SWEEP_LOW_TILT;
                res_pan  = right_reg;
            end
            if (passes_inc >= PASS_LIM)
            begin
                passes_next = 2'd0;
                res_verdict = btc_pkg::VERDICT_RIGHT;
            end
            else
            begin
                passes_next = passes_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_dir_reg <= 1'b0;
            saw_reg       <= 1'b0;
            last_col_reg  <= '0;
            passes_reg    <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            sweep_dir_reg <= sweep_dir_next;
            saw_reg       <= saw_next;
            last_col_reg  <= last_col_next;
            passes_reg    <= passes_next;
            out_valid_reg <= 1'b1;
        end
        else if (command.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            verdict_reg  <= res_verdict;
            move_reg     <= res_move;
            tilt_out_reg <= res_tilt;
            pan_out_reg  <= res_pan;
        end
    end

    assign stat.need_div  = seen_reg && !in_centre;
    assign stat.div_done  = div_done;
    assign stat.slot_free = !out_valid_reg || command.ready;

    assign command.valid       = out_valid_reg;
    assign command.verdict     = verdict_reg;
    assign command.move_valid  = move_reg;
    assign command.tilt_target = tilt_out_reg;
    assign command.pan_target  = pan_out_reg;

    a_no_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !move_reg |-> tilt_out_reg == '0 && pan_out_reg == '0)
        else $error("targets not zero on a word without a move");

    a_found_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && move_reg |-> verdict_reg != btc_pkg::VERDICT_FOUND)
        else $error("found verdict carries a move");

    a_div_only_outside: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_tilt |-> seen_reg && !in_centre)
        else $error("division started for a report that needs none");

    a_found_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && verdict_reg == btc_pkg::VERDICT_FOUND |->
            !saw_reg && passes_reg == 2'd0)
        else $error("found word without cleared tracking state");

endmodule

@@ rtl/ball_tracking_head_controller_core.sv @@
// Top level of the ball tracking head controller.
//
// Channels: report (sink) takes one camera-frame word per frame; command
// (source) gives one verdict word per report, with an optional tilt/pan move;
// cfg (sink) writes the image size and pan limits and is always ready.
// Sequence: a ball inside the centre rectangle, a lost ball or a sweep step
// passes from acceptance through the PREP and EMIT states, and the word is
// then registered in the output register, raising command valid. A ball
// outside the centre needs two serial divisions on one shared restoring
// divider, tilt in DIV_TILT, then pan in DIV_PAN, each result captured when
// the divider signals done. Flow: one report is worked on at a time; the
// next is accepted once the previous word is registered and the sequencer
// is back in idle.
// Reset: the registers return to 640x480 and pan limits of -90/+90 degrees;
// sweep direction, ball memory and sweep count are cleared; no word is held.
// Stall: a command word waits in the output register until taken; a report
// that finishes meanwhile holds in its last step and report stays not ready.
module ball_tracking_head_controller_core #(
    parameter int COORD_BITS         = 12,
    parameter int PASSES_BEFORE_TURN = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    btc_report_if.sink     report,
    btc_command_if.source  command,
    btc_cfg_if.sink        cfg
);

    btc_pkg::btc_cmd_t  cmd;
    btc_pkg::btc_stat_t stat;

    assign report.ready = cmd.in_ready;
    assign cfg.ready    = 1'b1;

    btc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .report_valid (report.valid),
        .stat         (stat),
        .cmd          (cmd)
    );

    btc_dp #(
        .COORD_BITS         (COORD_BITS),
        .PASSES_BEFORE_TURN (PASSES_BEFORE_TURN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .ball_seen   (report.ball_seen),
        .ball_col    (report.ball_col),
        .ball_row    (report.ball_row),
        .tilt_now    (report.tilt_now),
        .pan_now     (report.pan_now),
        .head_moving (report.head_moving),
        .command     (command)
    );

endmodule
